[design/crcf_pkg.sv]
// Shared types, constants and the byte-wide CRC-32 step of the frame checker.
// No dependencies; used by every module under design/ except crcf_in_stage.
package crcf_pkg;

   localparam logic [31:0] CRC_POLY      = 32'hEDB8_8320;
   localparam logic [31:0] CRC_INIT      = 32'hFFFF_FFFF;
   localparam logic [7:0]  START_BYTE    = 8'h01;
   localparam logic [7:0]  END_BYTE      = 8'h04;
   localparam logic [11:0] MIN_FRAME     = 12'd12;
   localparam logic [11:0] COUNT_MAX     = 12'hFFF;
   localparam logic [11:0] MAX_LEN_RESET = 12'd2060;
   localparam int          TAIL_DEPTH    = 5;

   // Header byte positions
   localparam logic [11:0] POS_START   = 12'd0;
   localparam logic [11:0] POS_CMD_HI  = 12'd3;
   localparam logic [11:0] POS_CMD_LO  = 12'd4;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_BAD_LEN = 2'd1,
      STATUS_BAD_MRK = 2'd2,
      STATUS_BAD_CRC = 2'd3
   } status_type;

   typedef struct packed {
      status_type  status;
      logic [15:0] command;
      logic [11:0] frame_length;
   } result_type;

   // Reflected CRC-32, one byte, bit steps unrolled.
   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
      end
      return c;
   endfunction

endpackage

[design/crcf_in_stage.sv]
// Input register of the frame checker: holds one byte transaction until the
// frame core takes it. Depends on nothing but the clock and reset.
module crcf_in_stage (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  logic [7:0] push_byte,
   input  logic       push_last,
   input  logic       pop,
   output logic       item_valid,
   output logic [7:0] item_byte,
   output logic       item_last
);

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff;
   logic       last_ff;

   always_comb begin
      valid_in = valid_ff;
      if (push) begin
         valid_in = 1'b1;
      end else if (pop) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         byte_ff <= push_byte;
         last_ff <= push_last;
      end
   end

   assign item_valid = valid_ff;
   assign item_byte  = byte_ff;
   assign item_last  = last_ff;

endmodule

[design/crcf_frame_core.sv]
// Frame state of the checker: running CRC, five-byte tail line, byte count,
// header capture, length limit register and the end-of-frame checks.
// Depends on crcf_pkg.
module crcf_frame_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr,
   input  logic [11:0]         csr_value,
   input  logic                step,
   input  logic [7:0]          step_byte,
   input  logic                step_last,
   output logic                res_valid,
   output crcf_pkg::result_type res
);

   logic [31:0] crc_ff, crc_in;
   logic [7:0]  tail_ff [crcf_pkg::TAIL_DEPTH];
   logic [7:0]  tail_in [crcf_pkg::TAIL_DEPTH];
   logic [11:0] count_ff, count_in;
   logic [7:0]  start_ff, start_in;
   logic [15:0] cmd_ff, cmd_in;
   logic [11:0] max_len_ff;
   logic [31:0] crc_fin;
   logic        crc_ok;
   crcf_pkg::status_type status;

   always_comb begin
      start_in = start_ff;
      cmd_in   = cmd_ff;
      if (count_ff == crcf_pkg::POS_START) begin
         start_in = step_byte;
      end else if (count_ff == crcf_pkg::POS_CMD_HI) begin
         cmd_in[15:8] = step_byte;
      end else if (count_ff == crcf_pkg::POS_CMD_LO) begin
         cmd_in[7:0] = step_byte;
      end

      // oldest tail byte enters the CRC once the line is full
      crc_in = crc_ff;
      if (count_ff >= 12'(crcf_pkg::TAIL_DEPTH)) begin
         crc_in = crcf_pkg::crc_byte(crc_ff, tail_ff[0]);
      end
      for (int k = 0; k < crcf_pkg::TAIL_DEPTH - 1; k++) begin
         tail_in[k] = tail_ff[k + 1];
      end
      tail_in[crcf_pkg::TAIL_DEPTH - 1] = step_byte;

      count_in = (count_ff < crcf_pkg::COUNT_MAX) ? 12'(count_ff + 12'd1) : count_ff;

      crc_fin = ~crc_in;
      crc_ok  = (tail_in[0] == crc_fin[31:24]) && (tail_in[1] == crc_fin[23:16]) &&
                (tail_in[2] == crc_fin[15:8])  && (tail_in[3] == crc_fin[7:0]);

      if ((count_in > max_len_ff) || (count_in < crcf_pkg::MIN_FRAME)) begin
         status = crcf_pkg::STATUS_BAD_LEN;
      end else if ((start_in != crcf_pkg::START_BYTE) ||
                   (tail_in[crcf_pkg::TAIL_DEPTH - 1] != crcf_pkg::END_BYTE)) begin
         status = crcf_pkg::STATUS_BAD_MRK;
      end else if (!crc_ok) begin
         status = crcf_pkg::STATUS_BAD_CRC;
      end else begin
         status = crcf_pkg::STATUS_OK;
      end

      res_valid        = step && step_last;
      res.status       = status;
      res.command      = (status == crcf_pkg::STATUS_OK) ? cmd_in : 16'd0;
      res.frame_length = count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= crcf_pkg::MAX_LEN_RESET;
      end else if (csr_wr) begin
         max_len_ff <= csr_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (step && step_last)) begin
         crc_ff   <= crcf_pkg::CRC_INIT;
         count_ff <= 12'd0;
         start_ff <= 8'd0;
         cmd_ff   <= 16'd0;
         for (int k = 0; k < crcf_pkg::TAIL_DEPTH; k++) begin
            tail_ff[k] <= 8'd0;
         end
      end else if (step) begin
         crc_ff   <= crc_in;
         count_ff <= count_in;
         start_ff <= start_in;
         cmd_ff   <= cmd_in;
         for (int k = 0; k < crcf_pkg::TAIL_DEPTH; k++) begin
            tail_ff[k] <= tail_in[k];
         end
      end
   end

endmodule

[design/crcf_out_reg.sv]
// Result register of the frame checker: holds one status transaction until
// the receiver takes it. Depends on crcf_pkg.
module crcf_out_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  crcf_pkg::result_type load_res,
   input  logic                 take,
   output logic                 res_valid,
   output crcf_pkg::result_type res
);

   logic                 valid_ff, valid_in;
   crcf_pkg::result_type res_ff;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         res_ff <= load_res;
      end
   end

   assign res_valid = valid_ff;
   assign res       = res_ff;

endmodule

[design/crc32_frame_checker.sv]
// Top level of the CRC-32 frame checker: input register, frame core and
// result register. Depends on crcf_pkg, crcf_in_stage, crcf_frame_core, crcf_out_reg.
//
// Usage:
//   req_* carries frame bytes, one per transaction; req_tlast marks the final
//   byte of a frame. For each byte with req_tlast set, one status transaction
//   leaves on rsp_* with status, command and frame length. Other bytes give
//   nothing. csr_* writes the longest accepted frame length (reset 2060).
//   Write csr only while no frame byte is in flight.
// Timing:
//   A byte is held in the input register and is folded into the frame state
//   as it leaves it; the status of a final byte is registered in the result
//   register, which drives rsp_tvalid. One byte per cycle is sustained; the
//   byte-wide CRC update is a single unrolled step. Only a final byte waits,
//   and only while an earlier status is still held with rsp_tready low; bytes
//   in the middle of a frame keep flowing during such a stall.
// Reset:
//   Synchronous, active high. Clears the frame state (CRC all ones, count,
//   tail line, header capture), empties both registers and restores the limit.
module crc32_frame_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // last_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [1:0] status, [17:2] command, [29:18] frame_length
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [11:0] csr_data     // max_frame_len
);

   logic                 item_valid;
   logic [7:0]           item_byte;
   logic                 item_last;
   logic                 step;
   logic                 out_busy;
   logic                 core_valid;
   crcf_pkg::result_type core_res;
   crcf_pkg::result_type out_res;

   assign out_busy   = rsp_tvalid && !rsp_tready;
   assign step       = item_valid && !(item_last && out_busy);
   assign req_tready = !item_valid || step;
   assign csr_ready  = 1'b1;

   crcf_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .push       (req_tvalid && req_tready),
      .push_byte  (req_tdata),
      .push_last  (req_tlast),
      .pop        (step),
      .item_valid (item_valid),
      .item_byte  (item_byte),
      .item_last  (item_last)
   );

   crcf_frame_core u_core (
      .clock     (clock),
      .reset     (reset),
      .csr_wr    (csr_valid && csr_ready),
      .csr_value (csr_data),
      .step      (step),
      .step_byte (item_byte),
      .step_last (item_last),
      .res_valid (core_valid),
      .res       (core_res)
   );

   crcf_out_reg u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (core_valid),
      .load_res  (core_res),
      .take      (rsp_tready),
      .res_valid (rsp_tvalid),
      .res       (out_res)
   );

   assign rsp_tdata = {2'b00, out_res.frame_length, out_res.command, out_res.status};

endmodule

[tb/crcf_status_checker.sv]
// Frame status checker: watches the byte, status and limit channels of the CRC-32 frame
// checker, tracks the frame state itself and compares each status transaction in order.
// Depends on crcf_pkg for the status codes, markers, header offsets and limits.
module crcf_status_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // last_byte
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,   // [1:0] status, [17:2] command, [29:18] frame_length
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [11:0] csr_data,    // max_frame_len
   output int          fail_count,
   output int          pending
);

   logic [11:0]          len_limit;
   logic [31:0]          crc_acc;
   logic [7:0]           tail_q [0:crcf_pkg::TAIL_DEPTH-1];
   logic [11:0]          byte_cnt;
   logic [7:0]           lead_byte;
   logic [15:0]          cmd_word;
   crcf_pkg::result_type status_expect_q [$];
   int                   errors = 0;

   // reflected CRC-32, one input bit at a time
   function automatic logic [31:0] crc_fold(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] r;
      r = crc;
      for (int i = 0; i < 8; i++) begin
         if (r[0] ^ b[i]) r = (r >> 1) ^ crcf_pkg::CRC_POLY;
         else r = r >> 1;
      end
      return r;
   endfunction

   task automatic clear_frame_state();
      crc_acc = crcf_pkg::CRC_INIT;
      for (int k = 0; k < crcf_pkg::TAIL_DEPTH; k++) tail_q[k] = 8'h00;
      byte_cnt  = 12'd0;
      lead_byte = 8'h00;
      cmd_word  = 16'h0000;
   endtask

   task automatic take_byte(input logic [7:0] b, input logic last);
      logic [31:0]          fin;
      crcf_pkg::result_type r;
      if (byte_cnt == crcf_pkg::POS_START) lead_byte = b;
      else if (byte_cnt == crcf_pkg::POS_CMD_HI) cmd_word[15:8] = b;
      else if (byte_cnt == crcf_pkg::POS_CMD_LO) cmd_word[7:0] = b;
      // oldest held byte enters the CRC once the tail line is full
      if (byte_cnt >= crcf_pkg::TAIL_DEPTH) crc_acc = crc_fold(crc_acc, tail_q[0]);
      for (int k = 0; k < crcf_pkg::TAIL_DEPTH - 1; k++) tail_q[k] = tail_q[k+1];
      tail_q[crcf_pkg::TAIL_DEPTH-1] = b;
      if (byte_cnt != crcf_pkg::COUNT_MAX) byte_cnt = byte_cnt + 12'd1;
      if (last) begin
         fin = ~crc_acc;
         if (byte_cnt > len_limit || byte_cnt < crcf_pkg::MIN_FRAME) begin
            r.status = crcf_pkg::STATUS_BAD_LEN;
         end else if (lead_byte != crcf_pkg::START_BYTE ||
                      tail_q[4] != crcf_pkg::END_BYTE) begin
            r.status = crcf_pkg::STATUS_BAD_MRK;
         end else if ({tail_q[0], tail_q[1], tail_q[2], tail_q[3]} != fin) begin
            r.status = crcf_pkg::STATUS_BAD_CRC;
         end else begin
            r.status = crcf_pkg::STATUS_OK;
         end
         r.command      = (r.status == crcf_pkg::STATUS_OK) ? cmd_word : 16'h0000;
         r.frame_length = byte_cnt;
         status_expect_q.push_back(r);
         clear_frame_state();
      end
   endtask

   task automatic check_status(input logic [31:0] word);
      crcf_pkg::result_type want;
      if (status_expect_q.size() == 0) begin
         if (errors < 10)
            $display("%t: status transaction with none expected, tdata %h", $time, word);
         errors++;
      end else begin
         want = status_expect_q.pop_front();
         if (word[1:0] !== want.status || word[17:2] !== want.command ||
             word[29:18] !== want.frame_length || word[31:30] !== 2'b00) begin
            if (errors < 10)
               $display("%t: status mismatch: expected status %0d cmd %h len %0d,",
                        $time, want.status, want.command, want.frame_length,
                        " got status %0d cmd %h len %0d pad %b",
                        word[1:0], word[17:2], word[29:18], word[31:30]);
            errors++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         len_limit = crcf_pkg::MAX_LEN_RESET;
         clear_frame_state();
         status_expect_q.delete();
      end else begin
         // a status leaving now belongs to an earlier byte, so pop before push
         if (rsp_tvalid && rsp_tready) check_status(rsp_tdata);
         if (csr_valid && csr_ready) len_limit = csr_data;
         if (req_tvalid && req_tready) take_byte(req_tdata, req_tlast);
      end
      pending    <= status_expect_q.size();
      fail_count <= errors;
   end

endmodule

[tb/crc32_frame_checker_tb.sv]
// Testbench top for crc32_frame_checker: builds good and damaged frames, drives bytes,
// status back-pressure and limit writes. Depends on crcf_pkg and crcf_status_checker.
module crc32_frame_checker_tb;

   localparam int IDLE_LIMIT  = 5000;
   localparam int HOLD_CYCLES = 400;
   localparam int PHASE_ITEMS = 65;

   typedef enum {
      FRAME_GOOD,
      FRAME_BAD_START,
      FRAME_BAD_END,
      FRAME_BAD_CRC,
      FRAME_BAD_BODY,
      FRAME_NOISE
   } frame_kind_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;   // [7:0] data_byte
   logic        req_tlast  = 1'b0;    // last_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;            // [1:0] status, [17:2] command, [29:18] frame_length
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [11:0] csr_data   = 12'd0;   // max_frame_len

   int          fail_count;
   int          pending;
   logic        req_eager   = 1'b0;
   logic        hold_toggle = 1'b0;
   logic        hold_seen   = 1'b0;
   int          hold_left   = 0;
   int          rsp_gap     = 0;
   int          rsp_draw;
   logic        rsp_eager   = 1'b0;
   int          bytes_sent  = 0;
   int          idle_cycles = 0;
   logic [7:0]  frame_buf [0:4199];

   always #2 clock = ~clock;

   crc32_frame_checker dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   crcf_status_checker status_chk (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .fail_count (fail_count),
      .pending    (pending)
   );

   // Status receiver: random low stretch after each transaction, eager runs now and then,
   // and a long hold-off whenever the stimulus flips hold_toggle.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_toggle != hold_seen) begin
         hold_seen  <= hold_toggle;
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (rsp_tready && rsp_tvalid) begin
         if ($urandom_range(0, 15) == 0) rsp_eager <= ~rsp_eager;
         rsp_draw = rsp_eager ? 0 : $urandom_range(0, 14);
         rsp_gap    <= rsp_draw;
         rsp_tready <= (rsp_draw == 0);
      end else if (!rsp_tready) begin
         if (rsp_gap <= 1) rsp_tready <= 1'b1;
         if (rsp_gap > 0) rsp_gap <= rsp_gap - 1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("[crc32_frame_checker] ERROR");
         $finish;
      end
   end

   function automatic logic [31:0] crc_step(input logic [31:0] c, input logic [7:0] b);
      logic [31:0] r;
      r = c ^ {24'h0, b};
      repeat (8) r = r[0] ? ((r >> 1) ^ crcf_pkg::CRC_POLY) : (r >> 1);
      return r;
   endfunction

   // valid stays high across back-to-back transactions; it only drops for a gap
   task automatic send_byte(input logic [7:0] b, input logic last);
      int gap;
      gap = req_eager ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      bytes_sent++;
   endtask

   // Header: start, destination, spare, command hi/lo at offsets 3 and 4, spare.
   // For noise, body_len is the number of random bytes.
   task automatic send_frame(input frame_kind_type kind, input int body_len,
                             input logic [15:0] cmd);
      logic [31:0] crc;
      logic [7:0]  v;
      int          n;
      int          idx;
      if (kind == FRAME_NOISE) begin
         for (int k = 0; k < body_len; k++) frame_buf[k] = 8'($urandom);
         for (int k = 0; k < body_len; k++)
            send_byte(frame_buf[k], (k == body_len - 1) || ($urandom_range(0, 3) == 0));
      end else begin
         frame_buf[0] = crcf_pkg::START_BYTE;
         frame_buf[1] = 8'($urandom);
         frame_buf[2] = 8'($urandom);
         frame_buf[3] = cmd[15:8];
         frame_buf[4] = cmd[7:0];
         frame_buf[5] = 8'($urandom);
         n = 6;
         for (int k = 0; k < body_len; k++) begin
            frame_buf[n] = 8'($urandom);
            n++;
         end
         crc = crcf_pkg::CRC_INIT;
         for (int k = 0; k < n; k++) crc = crc_step(crc, frame_buf[k]);
         crc = ~crc;
         frame_buf[n]   = crc[31:24];
         frame_buf[n+1] = crc[23:16];
         frame_buf[n+2] = crc[15:8];
         frame_buf[n+3] = crc[7:0];
         frame_buf[n+4] = crcf_pkg::END_BYTE;
         n = n + 5;
         case (kind)
            FRAME_BAD_START: begin
               do v = 8'($urandom); while (v == crcf_pkg::START_BYTE);
               frame_buf[0] = v;
            end
            FRAME_BAD_END: begin
               do v = 8'($urandom); while (v == crcf_pkg::END_BYTE);
               frame_buf[n-1] = v;
            end
            FRAME_BAD_CRC: begin
               idx = n - 5 + $urandom_range(0, 3);
               frame_buf[idx] = frame_buf[idx] ^ (8'h01 << $urandom_range(0, 7));
            end
            FRAME_BAD_BODY: begin
               idx = $urandom_range(1, n - 6);
               frame_buf[idx] = frame_buf[idx] ^ (8'h01 << $urandom_range(0, 7));
            end
            default: ;
         endcase
         for (int k = 0; k < n; k++) send_byte(frame_buf[k], k == n - 1);
      end
   endtask

   task automatic send_random_frame(input int max_body);
      int          pick;
      int          body;
      logic [15:0] cmd;
      pick = $urandom_range(0, 19);
      body = ($urandom_range(0, 7) == 0) ? $urandom_range(0, max_body) : $urandom_range(0, 16);
      case ($urandom_range(0, 3))
         0:       cmd = 16'h0000;
         1:       cmd = 16'hFFFF;
         default: cmd = 16'($urandom);
      endcase
      if ($urandom_range(0, 5) == 0) req_eager = ~req_eager;
      if (pick < 11)      send_frame(FRAME_GOOD, body, cmd);
      else if (pick < 13) send_frame(FRAME_BAD_START, body, cmd);
      else if (pick < 15) send_frame(FRAME_BAD_END, body, cmd);
      else if (pick < 17) send_frame(FRAME_BAD_CRC, body, cmd);
      else if (pick < 19) send_frame(FRAME_BAD_BODY, body, cmd);
      else                send_frame(FRAME_NOISE, $urandom_range(1, 20), cmd);
   endtask

   task automatic run_phase(input int items);
      int stop;
      stop = bytes_sent + items;
      while (bytes_sent < stop) send_random_frame(40);
   endtask

   // stop offering bytes until every status is back, then let the pipeline settle
   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_limit(input logic [11:0] v);
      drain();
      csr_valid <= 1'b1;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // shortest passing frame, one-byte frame, CRC-correct frame one byte short
      send_frame(FRAME_GOOD, 1, 16'hFFFF);
      send_byte(8'hFF, 1'b1);
      send_frame(FRAME_GOOD, 0, 16'h0000);

      run_phase(PHASE_ITEMS);

      // long status hold-off while bytes keep coming back to back
      hold_toggle <= ~hold_toggle;
      req_eager = 1'b1;
      repeat (10) send_frame(FRAME_GOOD, $urandom_range(1, 4), 16'($urandom));
      req_eager = 1'b0;

      drain();
      run_phase(PHASE_ITEMS);

      write_limit(12'd12);
      run_phase(PHASE_ITEMS);
      write_limit(12'd4095);
      run_phase(PHASE_ITEMS);
      write_limit(12'd11);
      run_phase(PHASE_ITEMS);
      write_limit(12'd0);
      run_phase(PHASE_ITEMS);
      write_limit(12'd30);
      run_phase(PHASE_ITEMS);
      write_limit(12'($urandom_range(12, 60)));
      run_phase(PHASE_ITEMS);
      write_limit(12'($urandom_range(12, 4095)));
      run_phase(PHASE_ITEMS);
      write_limit(12'd2060);
      run_phase(PHASE_ITEMS);

      write_limit(12'd4095);
      run_phase(PHASE_ITEMS / 2);

      drain();
      if (fail_count == 0 && pending == 0)
         $display("[crc32_frame_checker] OK");
      else
         $display("[crc32_frame_checker] ERROR");
      $finish;
   end

endmodule
